// ===== rtl/qepc_pkg.sv =====
// qepc_pkg: shared types, action codes and the x4 transition table
// for the quadrature encoder position counter. No dependencies.
`timescale 1ns / 1ps

package qepc_pkg;

  localparam int unsigned PositionWidthDefault = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned DebounceWidth = 16;

  localparam logic DefButtonEnabled = 1'b1;
  localparam logic [DebounceWidth-1:0] DefDebounceMs = 16'd1;

  // config register indexes
  localparam logic CfgIdxButtonEnabled = 1'b0;
  localparam logic CfgIdxDebounceMs = 1'b1;

  typedef enum logic [2:0] {
    ACT_PIN_SAMPLE  = 3'd0,
    ACT_INIT_PINS   = 3'd1,
    ACT_SET_POS     = 3'd2,
    ACT_READ_DELTA  = 3'd3,
    ACT_BUTTON_EDGE = 3'd4,
    ACT_BUTTON_POLL = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0]                   action;
    logic                         clk_level;
    logic                         dt_level;
    logic [FieldWidth-1:0]        now_ms;
    logic signed [FieldWidth-1:0] new_position;
  } item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] position;
    logic signed [FieldWidth-1:0] delta;
    logic [FieldWidth-1:0]        event_count;
    logic                         button_pressed;
  } result_t;

  typedef struct packed {
    logic                     button_enabled;
    logic [DebounceWidth-1:0] debounce_ms;
  } cfg_t;

  // {prev, cur} -> step; a skipped state counts as +/-2
  function automatic logic signed [2:0] step_lookup(input logic [3:0] idx);
    logic signed [2:0] s;
    case (idx)
      4'h1, 4'h7, 4'h8, 4'hE: s = 3'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: s = -3'sd1;
      4'h3, 4'hC:             s = 3'sd2;
      4'h6, 4'h9:             s = -3'sd2;
      default:                s = 3'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/qepc_core.sv =====
// qepc_core: encoder/button state and the single-pass item logic.
// Depends on qepc_pkg.
`timescale 1ns / 1ps

module qepc_core #(
  parameter int unsigned POSITION_WIDTH = qepc_pkg::PositionWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  qepc_pkg::item_t   item_i,
  input  qepc_pkg::cfg_t    cfg_i,
  output qepc_pkg::result_t result_o
);

  localparam int unsigned FW = qepc_pkg::FieldWidth;

  logic [1:0]                       prev_pins_q, prev_pins_d;
  logic signed [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic signed [POSITION_WIDTH-1:0] ref_q, ref_d;
  logic [FW-1:0]                    evt_q, evt_d;
  logic                             latch_q, latch_d;
  logic [FW-1:0]                    last_press_q, last_press_d;

  logic [1:0]                       pins;
  logic signed [2:0]                step;
  logic signed [POSITION_WIDTH-1:0] diff;
  logic [FW-1:0]                    elapsed;

  assign pins    = {item_i.dt_level, item_i.clk_level};
  assign step    = qepc_pkg::step_lookup({prev_pins_q, pins});
  assign diff    = pos_q - ref_q;
  assign elapsed = item_i.now_ms - last_press_q;

  always_comb begin
    prev_pins_d  = prev_pins_q;
    pos_d        = pos_q;
    ref_d        = ref_q;
    evt_d        = evt_q;
    latch_d      = latch_q;
    last_press_d = last_press_q;
    result_o.delta          = '0;
    result_o.button_pressed = 1'b0;
    unique case (item_i.action)
      qepc_pkg::ACT_PIN_SAMPLE: begin
        pos_d       = pos_q + POSITION_WIDTH'(step);
        evt_d       = evt_q + FW'(1);
        prev_pins_d = pins;
      end
      qepc_pkg::ACT_INIT_PINS: prev_pins_d = pins;
      qepc_pkg::ACT_SET_POS: begin
        pos_d = POSITION_WIDTH'(item_i.new_position);
        ref_d = POSITION_WIDTH'(item_i.new_position);
      end
      qepc_pkg::ACT_READ_DELTA: begin
        result_o.delta = FW'(diff);
        ref_d          = pos_q;
      end
      qepc_pkg::ACT_BUTTON_EDGE: begin
        if (elapsed > FW'(cfg_i.debounce_ms)) begin
          latch_d      = 1'b1;
          last_press_d = item_i.now_ms;
        end
      end
      qepc_pkg::ACT_BUTTON_POLL: begin
        if (cfg_i.button_enabled && latch_q) begin
          latch_d                 = 1'b0;
          result_o.button_pressed = 1'b1;
        end
      end
      default: ;  // unused codes leave state alone
    endcase
    result_o.position    = FW'(pos_d);
    result_o.event_count = evt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q  <= '0;
      pos_q        <= '0;
      ref_q        <= '0;
      evt_q        <= '0;
      latch_q      <= 1'b0;
      last_press_q <= '0;
    end else if (step_i) begin
      prev_pins_q  <= prev_pins_d;
      pos_q        <= pos_d;
      ref_q        <= ref_d;
      evt_q        <= evt_d;
      latch_q      <= latch_d;
      last_press_q <= last_press_d;
    end
  end

endmodule

// ===== rtl/quadrature_encoder_position_counter_top.sv =====
// Quadrature encoder position counter, top level: handshake, config
// registers, input and result registers. Depends on qepc_pkg, qepc_core.
`timescale 1ns / 1ps

// One item is taken per clock; after acceptance the item lands in an
// input register, then one pass of table lookup plus a POSITION_WIDTH-bit
// add (or the 32-bit debounce subtract and compare) updates the state and
// fills the result register. Sustained rate is one item per cycle, limited
// only by out_stall_i. While a finished result waits downstream the input
// register can still take one item; once it holds that item the input
// stalls until the result is taken.
// Action codes: 0 pin sample (x4 decode, skipped states count +/-2),
// 1 init pins, 2 set position (also sets the delta reference), 3 read
// delta, 4 button edge (debounced on wrapping ms time), 5 button poll.
// Position wraps at POSITION_WIDTH bits and is sign-extended or truncated
// to 32 bits on the output. Config (index 0 button_enabled, index 1
// debounce_ms) is written through cfg_we_i; the user must do so only while
// no item is in flight, which the block itself does not enforce.
module quadrature_encoder_position_counter_top #(
  parameter int unsigned POSITION_WIDTH = qepc_pkg::PositionWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input item
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic        clk_level_i,
  input  logic        dt_level_i,
  input  logic [31:0] now_ms_i,
  input  logic signed [31:0] new_position_i,
  // result item
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] delta_o,
  output logic [31:0] event_count_o,
  output logic        button_pressed_o
);

  qepc_pkg::cfg_t    cfg_q;
  qepc_pkg::item_t   item_q;
  qepc_pkg::result_t res_d, res_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  logic              s1_adv;
  logic              core_step;

  // result register frees up when empty or taken this cycle
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign core_step  = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_enabled <= qepc_pkg::DefButtonEnabled;
      cfg_q.debounce_ms    <= qepc_pkg::DefDebounceMs;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qepc_pkg::CfgIdxButtonEnabled: cfg_q.button_enabled <= cfg_data_i[0];
        qepc_pkg::CfgIdxDebounceMs:    cfg_q.debounce_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.action       <= action_i;
      item_q.clk_level    <= clk_level_i;
      item_q.dt_level     <= dt_level_i;
      item_q.now_ms       <= now_ms_i;
      item_q.new_position <= new_position_i;
    end
  end

  qepc_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (core_step),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .result_o(res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_o       = res_q.position;
  assign delta_o          = res_q.delta;
  assign event_count_o    = res_q.event_count;
  assign button_pressed_o = res_q.button_pressed;

  // stall only while the input register holds an item
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // an item in flight with a free result register moves on next cycle
  a_item_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("item did not reach result register");

  // poll and read delta are different actions
  a_press_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && button_pressed_o |-> delta_o == '0)
    else $error("press reported together with a delta");

endmodule
